@@ design/lfu_cache_lru_tiebreak_assert.svh @@
// Assertion macros used by the cache design file.
`ifndef LFU_CACHE_LRU_TIEBREAK_ASSERT_SVH
`define LFU_CACHE_LRU_TIEBREAK_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define LFU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define LFU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/lfu_pkg.sv @@
// Package with the shared types and constants of the LFU cache.
`default_nettype none
package lfu_pkg;
  localparam int DEF_ENTRIES = 16;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CNT_W = 16;
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;
  localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;
  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_TOUCH,
    ST_EVICT,
    ST_INSERT
  } state_t;
endpackage
`default_nettype wire

@@ design/lfu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ design/lfu_cache_lru_tiebreak.sv @@
// LFU cache with least-recently-used tie break, scanned one entry per cycle.
// Each scan pass reads all ENTRIES entries through one RAM port.
// A hitting get or put takes a lookup pass and a touch pass; a missing get takes one pass.
// A missing put takes one lookup pass, one pass per eviction, and one insert pass.
// Capacity zero gives the result in the cycle after start; results cannot be stalled.
// Synchronous reset empties the cache and sets capacity to 16; no clearing pass.
`default_nettype none
module lfu_cache_lru_tiebreak
#(
  parameter int ENTRIES = lfu_pkg::DEF_ENTRIES
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       in_kind,
  input  wire logic [lfu_pkg::KEY_W-1:0]  in_key,
  input  wire logic [lfu_pkg::VAL_W-1:0]  in_value,
  output logic                            out_valid,
  output logic                            out_found,
  output logic [lfu_pkg::VAL_W-1:0]       out_read_value,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [lfu_pkg::CAP_W-1:0]  cfg_data
);
  import lfu_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int WW = (CW > CAP_W) ? CW : CAP_W;
  localparam int EW = KEY_W + VAL_W + CNT_W + IW;
  localparam int R_LO = 0;
  localparam int C_LO = IW;
  localparam int V_LO = IW + CNT_W;
  localparam int K_LO = IW + CNT_W + VAL_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
  localparam logic [CW-1:0] N_CNT = CW'(ENTRIES);

  state_t state_r, state_nxt;

  logic [CAP_W-1:0] cap_r;
  logic [CW-1:0]    occ_r;
  logic [ENTRIES-1:0] valid_r;
  logic [CW-1:0]    cnt_r;
  logic             p_vld_r;
  logic [IW-1:0]    p_idx_r;
  logic             kind_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  logic             hit_f_r, vic_f_r, nvic_f_r, ins_f_r;
  logic [IW-1:0]    hit_idx_r, vic_idx_r, nvic_idx_r;
  logic [IW-1:0]    hit_rank_r, vic_rank_r, nvic_rank_r;
  logic [CNT_W-1:0] vic_cnt_r, nvic_cnt_r;
  logic [VAL_W-1:0] hit_val_r;
  logic             out_valid_r, out_found_r;
  logic [VAL_W-1:0] out_val_r;

  logic             issue, pass_end, accept;
  logic             we;
  logic [EW-1:0]    wdata, rdata;
  logic [KEY_W-1:0] e_key;
  logic [VAL_W-1:0] e_val;
  logic [CNT_W-1:0] e_cnt;
  logic [IW-1:0]    e_rank;
  logic             e_v;
  logic [WW-1:0]    cap_eff;
  logic [WW-1:0]    occ_w, occ_dec_w;
  logic [IW-1:0]    nv_rank;
  logic             nv_take;

  assign e_key  = rdata[K_LO +: KEY_W];
  assign e_val  = rdata[V_LO +: VAL_W];
  assign e_cnt  = rdata[C_LO +: CNT_W];
  assign e_rank = rdata[R_LO +: IW];
  assign e_v    = valid_r[p_idx_r];

  assign cap_eff   = (WW'(cap_r) > WW'(ENTRIES)) ? WW'(ENTRIES) : WW'(cap_r);
  assign occ_w     = WW'(occ_r);
  assign occ_dec_w = WW'(occ_r - 1'b1);

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE) && !start;
  assign accept    = start && !busy;
  assign issue     = busy && (cnt_r < N_CNT);
  assign pass_end  = p_vld_r && (p_idx_r == LAST_IDX);

  assign nv_rank = (e_rank > vic_rank_r) ? e_rank - 1'b1 : e_rank;
  assign nv_take = p_vld_r && (p_idx_r != vic_idx_r) && e_v &&
                   (!nvic_f_r || e_cnt < nvic_cnt_r ||
                    (e_cnt == nvic_cnt_r && nv_rank > nvic_rank_r));

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_read_value = out_val_r;

  lfu_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (p_idx_r),
    .wdata (wdata),
    .raddr (cnt_r[IW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    we = 1'b0;
    wdata = rdata;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (cap_eff != '0)) begin
          state_nxt = ST_FIND;
        end
      end
      ST_FIND: begin
        if (pass_end) begin
          if (hit_f_r || (e_v && e_key == key_r)) begin
            state_nxt = ST_TOUCH;
          end else if (kind_r == KIND_GET) begin
            state_nxt = ST_IDLE;
          end else if (occ_w >= cap_eff && occ_r != '0) begin
            state_nxt = ST_EVICT;
          end else begin
            state_nxt = ST_INSERT;
          end
        end
      end
      ST_TOUCH: begin
        if (p_vld_r) begin
          if (p_idx_r == hit_idx_r) begin
            we = 1'b1;
            wdata[R_LO +: IW] = '0;
            if (e_cnt != COUNT_MAX) begin
              wdata[C_LO +: CNT_W] = e_cnt + 1'b1;
            end
            if (kind_r == KIND_PUT) begin
              wdata[V_LO +: VAL_W] = val_r;
            end
          end else if (e_v && e_rank < hit_rank_r) begin
            we = 1'b1;
            wdata[R_LO +: IW] = e_rank + 1'b1;
          end
        end
        if (pass_end) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EVICT: begin
        if (p_vld_r && p_idx_r != vic_idx_r && e_v && e_rank > vic_rank_r) begin
          we = 1'b1;
          wdata[R_LO +: IW] = e_rank - 1'b1;
        end
        if (pass_end) begin
          if (occ_dec_w >= cap_eff && occ_dec_w != '0) begin
            state_nxt = ST_EVICT;
          end else begin
            state_nxt = ST_INSERT;
          end
        end
      end
      ST_INSERT: begin
        if (p_vld_r) begin
          if (e_v) begin
            we = 1'b1;
            wdata[R_LO +: IW] = e_rank + 1'b1;
          end else if (!ins_f_r) begin
            we = 1'b1;
            wdata = {key_r, val_r, CNT_W'(1), IW'(0)};
          end
        end
        if (pass_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      occ_r       <= '0;
      valid_r     <= '0;
      cnt_r       <= '0;
      p_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
      hit_f_r     <= 1'b0;
      vic_f_r     <= 1'b0;
      nvic_f_r    <= 1'b0;
      ins_f_r     <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      p_vld_r     <= issue;
      p_idx_r     <= cnt_r[IW-1:0];
      if (issue) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (state_nxt != state_r || (state_r == ST_EVICT && pass_end)) begin
        cnt_r <= '0;
        p_vld_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          hit_f_r <= 1'b0;
          vic_f_r <= 1'b0;
          if (accept) begin
            kind_r <= in_kind;
            key_r  <= in_key;
            val_r  <= in_value;
            if (cap_eff == '0) begin
              out_valid_r <= 1'b1;
              out_found_r <= 1'b0;
              out_val_r   <= MISS_VALUE;
            end
          end
        end
        ST_FIND: begin
          if (p_vld_r && e_v) begin
            if (!hit_f_r && e_key == key_r) begin
              hit_f_r    <= 1'b1;
              hit_idx_r  <= p_idx_r;
              hit_rank_r <= e_rank;
              hit_val_r  <= e_val;
            end
            if (!vic_f_r || e_cnt < vic_cnt_r ||
                (e_cnt == vic_cnt_r && e_rank > vic_rank_r)) begin
              vic_f_r    <= 1'b1;
              vic_idx_r  <= p_idx_r;
              vic_rank_r <= e_rank;
              vic_cnt_r  <= e_cnt;
            end
          end
          nvic_f_r <= 1'b0;
          ins_f_r  <= 1'b0;
          if (state_nxt == ST_IDLE) begin
            out_valid_r <= 1'b1;
            out_found_r <= 1'b0;
            out_val_r   <= MISS_VALUE;
          end
        end
        ST_TOUCH: begin
          if (pass_end) begin
            out_valid_r <= 1'b1;
            out_found_r <= 1'b1;
            out_val_r   <= (kind_r == KIND_GET) ? hit_val_r : MISS_VALUE;
          end
        end
        ST_EVICT: begin
          if (p_vld_r && p_idx_r == vic_idx_r) begin
            valid_r[p_idx_r] <= 1'b0;
          end
          if (pass_end) begin
            occ_r      <= occ_r - 1'b1;
            vic_idx_r  <= nv_take ? p_idx_r : nvic_idx_r;
            vic_rank_r <= nv_take ? nv_rank : nvic_rank_r;
            vic_cnt_r  <= nv_take ? e_cnt : nvic_cnt_r;
            nvic_f_r   <= 1'b0;
          end else if (nv_take) begin
            nvic_f_r    <= 1'b1;
            nvic_idx_r  <= p_idx_r;
            nvic_rank_r <= nv_rank;
            nvic_cnt_r  <= e_cnt;
          end
        end
        ST_INSERT: begin
          if (p_vld_r && !e_v && !ins_f_r) begin
            ins_f_r          <= 1'b1;
            valid_r[p_idx_r] <= 1'b1;
          end
          if (pass_end) begin
            occ_r       <= occ_r + 1'b1;
            out_valid_r <= 1'b1;
            out_found_r <= 1'b0;
            out_val_r   <= MISS_VALUE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `include "lfu_cache_lru_tiebreak_assert.svh"

  `LFU_ASSERT_IMP(a_out_idle, out_valid, !busy)
  `LFU_ASSERT_IMP(a_occ_bound, 1'b1, occ_r <= N_CNT)
  `LFU_ASSERT_NEXT(a_start_moves, accept, busy || out_valid)
endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the LFU cache with least-recently-used tie break.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import lfu_pkg::*;

  localparam int SLOTS = DEF_ENTRIES;

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } op_t;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] read_value;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_kind = 1'b0;
  logic [KEY_W-1:0] in_key = '0;
  logic [VAL_W-1:0] in_value = '0;
  logic out_valid;
  logic out_found;
  logic [VAL_W-1:0] out_read_value;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CAP_W-1:0] cfg_data = '0;

  lfu_cache_lru_tiebreak dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_key(in_key), .in_value(in_value),
    .out_valid(out_valid), .out_found(out_found), .out_read_value(out_read_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Shadow copy of the cache contents.
  logic             sh_valid [SLOTS];
  logic [KEY_W-1:0] sh_key   [SLOTS];
  logic [VAL_W-1:0] sh_value [SLOTS];
  logic [CNT_W-1:0] sh_count [SLOTS];
  int unsigned      sh_rank  [SLOTS];
  int unsigned      sh_fill;
  logic [CAP_W-1:0] sh_capacity;

  op_t    pending_ops[$];
  reply_t expected_replies[$];
  int     accepted_ops = 0;
  bit     failed = 1'b0;
  bit     quiet_drive = 1'b0;

  function automatic void touch_slot(int s);
    for (int i = 0; i < SLOTS; i++)
      if (sh_valid[i] && sh_rank[i] < sh_rank[s]) sh_rank[i]++;
    sh_rank[s] = 0;
    if (sh_count[s] != COUNT_MAX) sh_count[s]++;
  endfunction

  function automatic void evict_victim();
    int v;
    v = -1;
    for (int i = 0; i < SLOTS; i++)
      if (sh_valid[i] && (v < 0 || sh_count[i] < sh_count[v] ||
          (sh_count[i] == sh_count[v] && sh_rank[i] > sh_rank[v]))) v = i;
    if (v < 0) begin
      sh_fill = 0;
      return;
    end
    sh_valid[v] = 1'b0;
    for (int i = 0; i < SLOTS; i++)
      if (sh_valid[i] && sh_rank[i] > sh_rank[v]) sh_rank[i]--;
    if (sh_fill > 0) sh_fill--;
  endfunction

  function automatic reply_t cache_access(op_t op);
    reply_t r;
    int unsigned cap;
    int s;
    int free_slot;
    r.found = 1'b0;
    r.read_value = MISS_VALUE;
    cap = (sh_capacity > SLOTS) ? SLOTS : sh_capacity;
    if (cap == 0) return r;
    s = -1;
    for (int i = SLOTS - 1; i >= 0; i--)
      if (sh_valid[i] && sh_key[i] == op.key) s = i;
    if (s >= 0) begin
      r.found = 1'b1;
      if (op.kind == KIND_GET) begin
        r.read_value = sh_value[s];
      end else begin
        sh_value[s] = op.value;
      end
      touch_slot(s);
      return r;
    end
    if (op.kind == KIND_PUT) begin
      while (sh_fill >= cap && sh_fill > 0) evict_victim();
      free_slot = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (!sh_valid[i]) begin
          if (free_slot < 0) free_slot = i;
        end else begin
          sh_rank[i]++;
        end
      end
      if (free_slot >= 0) begin
        sh_valid[free_slot] = 1'b1;
        sh_key[free_slot] = op.key;
        sh_value[free_slot] = op.value;
        sh_count[free_slot] = 1;
        sh_rank[free_slot] = 0;
        sh_fill++;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t next_reply;
    if (rst_n && start && !busy) begin
      next_reply = cache_access({in_kind, in_key, in_value});
      expected_replies = {expected_replies, next_reply};
      accepted_ops <= accepted_ops + 1;
    end
    if (!rst_n || (start && !busy)) begin
      if (rst_n && pending_ops.size() > 0 && (quiet_drive || $urandom_range(99) >= 6)) begin
        {in_kind, in_key, in_value} <= pending_ops.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end else if (!start && pending_ops.size() > 0 &&
                 (quiet_drive || $urandom_range(99) >= 6)) begin
      {in_kind, in_key, in_value} <= pending_ops.pop_front();
      start <= 1'b1;
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected result found=%0b read_value=%h",
                 $time, out_found, out_read_value);
        failed = 1'b1;
      end else begin
        want = expected_replies.pop_front();
        if (want.found !== out_found) begin
          $display("%0t: found expected %0b actual %0b", $time, want.found, out_found);
          failed = 1'b1;
        end
        if (want.read_value !== out_read_value) begin
          $display("%0t: read_value expected %h actual %h",
                   $time, want.read_value, out_read_value);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic add_op(logic kind, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
    op_t op;
    op.kind = kind;
    op.key = key;
    op.value = value;
    pending_ops = {pending_ops, op};
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    @(posedge clk);
    cfg_data <= cap;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sh_capacity = cap;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    int total;
    total = accepted_ops + pending_ops.size() + (start ? 1 : 0);
    wait (pending_ops.size() == 0 && !start && accepted_ops == total &&
          expected_replies.size() == 0);
    repeat (8 * SLOTS + 20) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key(int pool);
    if ($urandom_range(19) == 0) return $urandom();
    return $urandom_range(pool - 1) ^ 32'h8000_0000;
  endfunction

  task automatic queue_random(int count, int pool, int put_pct);
    logic kind;
    for (int i = 0; i < count; i++) begin
      kind = ($urandom_range(99) < put_pct) ? KIND_PUT : KIND_GET;
      add_op(kind, pick_key(pool), $urandom());
    end
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      sh_valid[i] = 1'b0; sh_key[i] = '0; sh_value[i] = '0;
      sh_count[i] = '0; sh_rank[i] = 0;
    end
    sh_fill = 0;
    sh_capacity = CAP_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    add_op(KIND_GET, 32'h8000_0000, 32'h0);
    add_op(KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    add_op(KIND_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    add_op(KIND_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_op(KIND_PUT, 32'h0, 32'h0);
    add_op(KIND_GET, 32'h7FFF_FFFF, 32'h0);
    add_op(KIND_GET, 32'hFFFF_FFFF, 32'h1234_5678);
    add_op(KIND_PUT, 32'h0, 32'hA5A5_5A5A);
    add_op(KIND_GET, 32'h0, 32'h0);
    for (int i = 1; i <= 14; i++)
      add_op(KIND_PUT, KEY_W'(i), VAL_W'(~i));
    add_op(KIND_GET, 32'h8000_0000, 32'h0);
    drain();

    write_capacity(5'd0);
    add_op(KIND_PUT, 32'h55, 32'h66);
    add_op(KIND_GET, 32'h0, 32'h0);
    drain();

    write_capacity(5'd3);
    queue_random(60, 6, 50);
    drain();
    write_capacity(5'd31);
    queue_random(60, 24, 50);
    drain();
    write_capacity(5'd1);
    queue_random(50, 3, 50);
    drain();

    // Build up one entry's use count, then force evictions around it.
    write_capacity(5'd2);
    add_op(KIND_PUT, 32'hC0DE, 32'h1);
    drain();
    quiet_drive = 1'b1;
    for (int i = 0; i < 40; i++) begin
      add_op(KIND_GET, 32'hC0DE, $urandom());
      if (pending_ops.size() > 64) wait (pending_ops.size() < 32);
    end
    drain();
    quiet_drive = 1'b0;
    queue_random(20, 5, 70);
    drain();

    write_capacity(5'd16);
    quiet_drive = 1'b1;
    queue_random(150, 20, 40);
    drain();
    quiet_drive = 1'b0;
    for (int phase = 0; phase < 8; phase++) begin
      write_capacity(phase == 7 ? 5'd17 : CAP_W'($urandom_range(31)));
      queue_random(130, 4 + $urandom_range(24), 30 + $urandom_range(40));
      drain();
    end

    if (!failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire
